### rtl/icy_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icy_pkg: shared types and constants of the icy metadata demultiplexer
// result kinds, parser phases, the title key and the result bundle format
// ----------------------------------------------------------------------------
package icy_pkg;

	// kind of one result item
	typedef enum logic [1:0] {
		KIND_AUDIO   = 2'd0,
		KIND_CHAR    = 2'd1,
		KIND_DONE    = 2'd2,
		KIND_DISCARD = 2'd3
	} kind_t;

	// stream parser phase
	typedef enum logic [1:0] {
		PH_AUDIO = 2'd0,
		PH_LEN   = 2'd1,
		PH_META  = 2'd2
	} phase_t;

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
	} result_t;

	// all results caused by one input byte, slot 0 first
	localparam int unsigned MAX_RES = 3;
	typedef struct packed {
		result_t [MAX_RES-1:0] res;
		logic [1:0]            cnt;
	} bundle_t;

	localparam logic [15:0] INTERVAL_RESET = 16'd8192;
	localparam logic [3:0]  KEY_LEN        = 4'd13;
	localparam logic [3:0]  MATCH_DONE     = 4'd15;
	localparam logic [7:0]  CH_QUOTE       = 8'h27;
	localparam logic [7:0]  CH_SEMI        = 8'h3B;
	localparam logic [7:0]  CH_KEY_FIRST   = 8'h53;

	// characters of StreamTitle='
	function automatic logic [7:0] key_char(input logic [3:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = 8'h53; // S
			4'd1:    c = 8'h74; // t
			4'd2:    c = 8'h72; // r
			4'd3:    c = 8'h65; // e
			4'd4:    c = 8'h61; // a
			4'd5:    c = 8'h6D; // m
			4'd6:    c = 8'h54; // T
			4'd7:    c = 8'h69; // i
			4'd8:    c = 8'h74; // t
			4'd9:    c = 8'h6C; // l
			4'd10:   c = 8'h65; // e
			4'd11:   c = 8'h3D; // =
			4'd12:   c = 8'h27; // '
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### rtl/icy_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icy_parse: stream parser of the icy metadata demultiplexer
// tracks audio/length/metadata phases, matches the title key and builds the
// bundle of results for each accepted byte
// ----------------------------------------------------------------------------
module icy_parse import icy_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        take,
	input  logic [7:0]  in_byte,
	output bundle_t     bundle
);

	phase_t      phase_q, phase_d;
	logic [15:0] interval_q;
	logic [15:0] audio_cnt_q, audio_cnt_d;
	logic [11:0] meta_len_q, meta_len_d;
	logic [11:0] meta_cnt_q, meta_cnt_d;
	logic [11:0] meta_cnt_inc;
	logic [3:0]  match_q, match_d;
	logic        in_title_q, in_title_d;
	logic        quote_q, quote_d;
	logic        finished;
	logic        hit;
	logic [3:0]  match_nx;
	logic [4:0]  match_inc;
	logic [1:0]  n;

	assign meta_cnt_inc = meta_cnt_q + 12'd1;
	assign match_inc    = {1'b0, match_q} + 5'd1;

	// key matcher step on the current byte
	always_comb begin
		hit      = 1'b0;
		match_nx = 4'd0;
		if (match_q < KEY_LEN && in_byte == key_char(match_q)) begin
			if (match_inc[3:0] == KEY_LEN) begin
				hit = 1'b1;
			end else begin
				match_nx = match_inc[3:0];
			end
		end else if (in_byte == CH_KEY_FIRST) begin
			match_nx = 4'd1;
		end
	end

	// next state and result bundle
	always_comb begin
		phase_d     = phase_q;
		audio_cnt_d = audio_cnt_q;
		meta_len_d  = meta_len_q;
		meta_cnt_d  = meta_cnt_q;
		match_d     = match_q;
		in_title_d  = in_title_q;
		quote_d     = quote_q;
		finished    = 1'b0;
		n           = 2'd0;
		bundle      = '0;
		unique case (phase_q)
			PH_LEN: begin
				meta_len_d  = {in_byte, 4'b0000};
				meta_cnt_d  = '0;
				match_d     = '0;
				in_title_d  = 1'b0;
				quote_d     = 1'b0;
				audio_cnt_d = '0;
				phase_d     = (in_byte == 8'd0) ? PH_AUDIO : PH_META;
			end
			PH_META: begin
				if (match_q != MATCH_DONE) begin
					// held quote: terminator or plain character
					if (in_title_q && quote_q) begin
						quote_d = 1'b0;
						if (in_byte == CH_SEMI) begin
							bundle.res[n] = '{kind: KIND_DONE, value: 8'd0};
							n          = n + 2'd1;
							in_title_d = 1'b0;
							match_d    = MATCH_DONE;
							finished   = 1'b1;
						end else begin
							bundle.res[n] = '{kind: KIND_CHAR, value: CH_QUOTE};
							n = n + 2'd1;
						end
					end
					if (!finished) begin
						match_d = match_nx;
						if (in_title_q) begin
							if (hit) begin
								bundle.res[n] = '{kind: KIND_DISCARD, value: 8'd0};
								n = n + 2'd1;
							end else if (in_byte == CH_QUOTE) begin
								quote_d = 1'b1;
							end else begin
								bundle.res[n] = '{kind: KIND_CHAR, value: in_byte};
								n = n + 2'd1;
							end
						end else if (hit) begin
							in_title_d = 1'b1;
							quote_d    = 1'b0;
						end
					end
				end
				// end of the metadata block
				meta_cnt_d = meta_cnt_inc;
				if (meta_cnt_inc == meta_len_q) begin
					if (in_title_d) begin
						bundle.res[n] = '{kind: KIND_DISCARD, value: 8'd0};
						n = n + 2'd1;
					end
					in_title_d  = 1'b0;
					quote_d     = 1'b0;
					match_d     = '0;
					meta_cnt_d  = '0;
					audio_cnt_d = '0;
					phase_d     = PH_AUDIO;
				end
			end
			default: begin
				// audio passes straight through
				bundle.res[n] = '{kind: KIND_AUDIO, value: in_byte};
				n = n + 2'd1;
				audio_cnt_d = audio_cnt_q + 16'd1;
				if (audio_cnt_d == interval_q) begin
					audio_cnt_d = '0;
					phase_d     = PH_LEN;
				end
			end
		endcase
		bundle.cnt = n;
	end

	// interval register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_data;
		end
	end

	// parser state, updated on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_AUDIO;
			audio_cnt_q <= '0;
			meta_len_q  <= '0;
			meta_cnt_q  <= '0;
			match_q     <= '0;
			in_title_q  <= 1'b0;
			quote_q     <= 1'b0;
		end else if (take) begin
			phase_q     <= phase_d;
			audio_cnt_q <= audio_cnt_d;
			meta_len_q  <= meta_len_d;
			meta_cnt_q  <= meta_cnt_d;
			match_q     <= match_d;
			in_title_q  <= in_title_d;
			quote_q     <= quote_d;
		end
	end

endmodule

### rtl/icy_ser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icy_ser: result serializer of the icy metadata demultiplexer
// holds the bundle of one byte and hands its results out one per cycle while
// the sink is ready, through an output register
// ----------------------------------------------------------------------------
module icy_ser import icy_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  bundle_t    bundle,
	output logic       can_load,
	output logic       out_valid,
	input  logic       out_ready,
	output kind_t      out_kind,
	output logic [7:0] out_value,
	output logic       out_last
);

	bundle_t    bun_s1;
	logic [1:0] cnt_s1;
	logic [1:0] idx_q;
	logic [1:0] remain;
	logic [1:0] idx_inc;
	logic       out_free;
	logic       move;
	logic       valid_q;
	result_t    res_q;
	logic       last_q;

	assign remain   = cnt_s1 - idx_q;
	assign idx_inc  = idx_q + 2'd1;
	assign out_free = !valid_q || out_ready;
	assign move     = out_free && (remain != 2'd0);
	assign can_load = (remain == 2'd0) || (remain == 2'd1 && out_free);

	// bundle register and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
			idx_q  <= '0;
		end else if (load) begin
			cnt_s1 <= bundle.cnt;
			idx_q  <= '0;
		end else if (move) begin
			idx_q <= idx_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bun_s1 <= bundle;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (move) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_q  <= bun_s1.res[idx_q];
			last_q <= (idx_inc == cnt_s1);
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = res_q.kind;
	assign out_value = res_q.value;
	assign out_last  = last_q;

endmodule

### rtl/icy_metadata_demux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icy_metadata_demux: splits an icy stream body into audio and title items
// ----------------------------------------------------------------------------
// Takes the stream body one byte per item and gives audio bytes, title
// characters and title complete/discarded markers. The parser updates its
// state in the cycle a byte is accepted, so a byte can enter every cycle the
// serializer has room; one-result bytes sustain one byte per cycle to a ready
// sink. A byte gives zero to three results (length bytes give none) and the
// output moves one result per cycle to a ready sink, so a byte with more
// results holds the input longer. Results pass the bundle and output registers.
// The metadata interval register may only be written while the block is idle.
// ----------------------------------------------------------------------------
module icy_metadata_demux import icy_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: metadata_interval
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] value
	output logic [1:0]  m_tuser,  // [1:0] kind
	output logic        m_tlast   // last result of this byte
);

	bundle_t bundle;
	logic    take;
	logic    can_load;
	kind_t   out_kind;

	assign cfg_ready = 1'b1;
	assign s_tready  = can_load;
	assign take      = s_tvalid && can_load;

	// stream parser
	icy_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.take     (take),
		.in_byte  (s_tdata),
		.bundle   (bundle)
	);

	// result serializer
	icy_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.bundle    (bundle),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (out_kind),
		.out_value (m_tdata),
		.out_last  (m_tlast)
	);

	assign m_tuser = out_kind;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of icy_metadata_demux
// ----------------------------------------------------------------------------
// Feeds stream bodies built from audio runs, length bytes and metadata
// blocks with stream titles, predicts every result item with an own model of
// the parser and compares the result stream field by field. Runs directed
// title cases at the shortest interval, then random phases with random
// source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
	import icy_pkg::*;

	localparam int RESET_CYCLES   = 11;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_ITEMS   = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [8*13-1:0] TITLE_KEY = "StreamTitle='";

	// one predicted result item
	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} demux_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// stream body waiting to be sent, results still due, metadata under construction
	logic [7:0] body_q[$];
	demux_res_t due_results[$];
	logic [7:0] meta_buf[$];
	int         queued_bytes = 0;
	int         errors = 0;

	logic src_idle = 1'b0;
	logic sink_idle = 1'b0;
	int   src_wait = 0;
	int   sink_wait = 0;
	int   sink_draw;
	int   quiet_cycles = 0;
	demux_res_t want;

	// parser state of the prediction
	phase_t      parse_phase = PH_AUDIO;
	logic [15:0] interval_reg = INTERVAL_RESET;
	logic [15:0] audio_cnt = 16'd0;
	logic [11:0] meta_len = 12'd0;
	logic [11:0] meta_cnt = 12'd0;
	logic [3:0]  match_pos = 4'd0;
	logic        in_title = 1'b0;
	logic        quote_held = 1'b0;

	icy_metadata_demux i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int draw_wait(input logic idle_on);
		return idle_on ? int'($urandom_range(0, 9)) : 0;
	endfunction

	function automatic logic [7:0] key_at(input int pos);
		return TITLE_KEY[(12 - pos) * 8 +: 8];
	endfunction

	// title key matcher, true when the whole key was just seen
	function automatic logic key_advance(input logic [7:0] b);
		if (match_pos < KEY_LEN && b == key_at(match_pos)) begin
			match_pos = match_pos + 4'd1;
			if (match_pos == KEY_LEN) begin
				match_pos = 4'd0;
				return 1'b1;
			end
		end else begin
			match_pos = (b == key_at(0)) ? 4'd1 : 4'd0;
		end
		return 1'b0;
	endfunction

	task automatic due_result(input kind_t k, input logic [7:0] v);
		demux_res_t r;
		r.kind  = k;
		r.value = v;
		r.last  = 1'b0;
		due_results.push_back(r);
	endtask

	// results caused by one accepted body byte
	task automatic predict_byte(input logic [7:0] b);
		int         base;
		logic       hit;
		logic       finished;
		demux_res_t tail;
		base = due_results.size();
		case (parse_phase)
			PH_LEN: begin
				meta_len    = {b, 4'h0};
				meta_cnt    = 12'd0;
				match_pos   = 4'd0;
				in_title    = 1'b0;
				quote_held  = 1'b0;
				parse_phase = (meta_len == 12'd0) ? PH_AUDIO : PH_META;
				audio_cnt   = 16'd0;
			end
			PH_META: begin
				if (match_pos != MATCH_DONE) begin
					finished = 1'b0;
					// a held quote is either the terminator or a title character
					if (in_title && quote_held) begin
						quote_held = 1'b0;
						if (b == CH_SEMI) begin
							due_result(KIND_DONE, 8'h00);
							in_title  = 1'b0;
							match_pos = MATCH_DONE;
							finished  = 1'b1;
						end else begin
							due_result(KIND_CHAR, CH_QUOTE);
						end
					end
					if (!finished) begin
						hit = key_advance(b);
						if (in_title) begin
							if (hit)
								due_result(KIND_DISCARD, 8'h00);
							else if (b == CH_QUOTE)
								quote_held = 1'b1;
							else
								due_result(KIND_CHAR, b);
						end else if (hit) begin
							in_title   = 1'b1;
							quote_held = 1'b0;
						end
					end
				end
				// end of the metadata block
				meta_cnt = meta_cnt + 12'd1;
				if (meta_cnt == meta_len) begin
					if (in_title)
						due_result(KIND_DISCARD, 8'h00);
					in_title    = 1'b0;
					quote_held  = 1'b0;
					match_pos   = 4'd0;
					meta_cnt    = 12'd0;
					audio_cnt   = 16'd0;
					parse_phase = PH_AUDIO;
				end
			end
			default: begin
				due_result(KIND_AUDIO, b);
				audio_cnt = audio_cnt + 16'd1;
				if (audio_cnt == interval_reg) begin
					audio_cnt   = 16'd0;
					parse_phase = PH_LEN;
				end
			end
		endcase
		if (due_results.size() > base) begin
			tail      = due_results.pop_back();
			tail.last = 1'b1;
			due_results.push_back(tail);
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		body_q.push_back(b);
		queued_bytes++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			meta_buf.push_back(s[i]);
	endtask

	task automatic add_key_prefix(input int n);
		for (int i = 0; i < n; i++)
			meta_buf.push_back(key_at(i));
	endtask

	task automatic add_terminator();
		meta_buf.push_back(CH_QUOTE);
		meta_buf.push_back(CH_SEMI);
	endtask

	// title text rich in quotes and semicolons
	task automatic add_title(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				meta_buf.push_back(CH_QUOTE);
			else if (r == 2)
				meta_buf.push_back(CH_SEMI);
			else if (r == 3)
				meta_buf.push_back(8'($urandom_range(0, 255)));
			else
				meta_buf.push_back(8'($urandom_range(32, 126)));
		end
	endtask

	// junk mixing key characters, semicolons and arbitrary bytes
	task automatic add_noise(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 3);
			if (r == 0)
				meta_buf.push_back(key_at($urandom_range(0, 12)));
			else if (r == 1)
				meta_buf.push_back(CH_SEMI);
			else
				meta_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// length byte and metadata block, padded or cut to 16 bytes per length unit
	task automatic push_meta(input int len_code);
		logic pad_rand;
		pad_rand = ($urandom_range(0, 3) == 0);
		push_byte(8'(len_code));
		for (int i = 0; i < 16 * len_code; i++) begin
			if (i < meta_buf.size())
				push_byte(meta_buf[i]);
			else
				push_byte(pad_rand ? 8'($urandom_range(0, 255)) : 8'h00);
		end
		meta_buf.delete();
	endtask

	task automatic push_block(input int n_audio, input int len_code);
		for (int i = 0; i < n_audio; i++)
			push_byte(8'($urandom_range(0, 255)));
		push_meta(len_code);
	endtask

	// metadata content, mostly well-formed titles with random text
	task automatic build_random_meta();
		int shape;
		meta_buf.delete();
		if ($urandom_range(0, 3) == 0)
			add_noise($urandom_range(1, 6));
		shape = $urandom_range(0, 9);
		case (shape)
			0: add_noise($urandom_range(0, 40));
			1: begin
				add_key_prefix($urandom_range(1, 12));
				add_key_prefix(KEY_LEN);
				add_title($urandom_range(0, 12));
				add_terminator();
			end
			2: begin
				add_key_prefix(KEY_LEN);
				add_title($urandom_range(0, 20));
			end
			3: begin
				add_key_prefix(KEY_LEN);
				add_title($urandom_range(0, 6));
				add_key_prefix(KEY_LEN);
				add_title($urandom_range(0, 6));
				add_terminator();
			end
			default: begin
				add_key_prefix(KEY_LEN);
				add_title($urandom_range(0, 16));
				add_terminator();
				if ($urandom_range(0, 2) == 0) begin
					add_key_prefix(KEY_LEN);
					add_title(3);
					add_terminator();
				end
			end
		endcase
		if ($urandom_range(0, 2) == 0)
			add_noise($urandom_range(0, 8));
	endtask

	task automatic write_interval(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		interval_reg = v;
		@(negedge clk);
	endtask

	// wait until every byte is in and every result is out, then let the block settle
	task automatic drain();
		@(negedge clk);
		while (body_q.size() != 0 || s_tvalid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// source side: one body byte per item with a random gap after it while src_idle is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			src_wait <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_wait > 0) begin
				src_wait <= src_wait - 1;
				s_tvalid <= 1'b0;
			end else if (body_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= body_q.pop_front();
				src_wait <= draw_wait(src_idle);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// prediction of accepted bytes, result checks and sink stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			sink_wait <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("result item with nothing due: kind %0d value %0d last %0d",
						m_tuser, m_tdata, m_tlast);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (m_tuser !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, m_tuser);
						errors++;
					end
					if (m_tdata !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						errors++;
					end
				end
				sink_draw = draw_wait(sink_idle);
				m_tready  <= (sink_draw == 0);
				sink_wait <= (sink_draw > 0) ? sink_draw - 1 : 0;
			end else if (sink_wait > 0) begin
				sink_wait <= sink_wait - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus phases
	initial begin
		int start_count;
		int block_len;
		int interval;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed title cases at the shortest interval
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		write_interval(16'd1);
		push_byte(8'h00);
		push_meta(0);
		push_byte(8'hFF);
		// held quote on the last metadata byte is dropped
		add_text("StreamTitle='xy'");
		push_meta(1);
		// quote inside the title, then completion and an ignored key
		add_text("StreamTitle='a'b';StreamTitle='");
		push_block(1, 2);
		// restart inside a title, completion on the last byte
		add_text("StreamTitle='abStreamTitle='cd';");
		push_block(1, 2);
		// metadata ends inside a title
		add_text("StreamTitle='abc");
		push_block(1, 1);
		// empty title
		add_text("StreamTitle='';");
		push_block(1, 1);
		// broken key prefix followed by a good key
		add_text("StStreamTitle='Q");
		push_block(1, 1);
		drain();

		// random phases with random interval and idling
		start_count = queued_bytes;
		while (queued_bytes - start_count < RANDOM_ITEMS) begin
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			interval  = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60)
				: $urandom_range(1, 12);
			write_interval(16'(interval));
			repeat ($urandom_range(1, 3)) begin
				build_random_meta();
				block_len = (meta_buf.size() + 15) / 16;
				case ($urandom_range(0, 7))
					0: if (block_len > 0) block_len--;
					1: block_len++;
					2: block_len = 0;
					default: ;
				endcase
				push_block(interval, block_len);
			end
			drain();
		end

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
